// File: sv/ctg_pkg.sv
// Shared types, tessellation constants and lookup tables for the collider triangle generator.
`timescale 1ns / 1ps
`default_nettype none
package ctg_pkg;

    localparam int RINGS    = 6;
    localparam int SEGMENTS = 8;
    localparam int RING_W   = $clog2(RINGS + 1);
    localparam int SEG_W    = $clog2(SEGMENTS);
    localparam int RING_MID = RINGS / 2;

    localparam int HULL_MID = 2 * (RINGS - 2) * SEGMENTS;
    localparam int HULL_CNT = 2 * (RINGS - 1) * SEGMENTS;
    localparam int CYL_CNT  = 2 * SEGMENTS;
    localparam int BOX_CNT  = 12;

    localparam logic [1:0] KIND_BOX     = 2'd0;
    localparam logic [1:0] KIND_SPHERE  = 2'd1;
    localparam logic [1:0] KIND_CAPSULE = 2'd2;

    // Triangle shapes within the hull walk.
    localparam logic [1:0] TRI_ABD   = 2'd0;
    localparam logic [1:0] TRI_DBC   = 2'd1;
    localparam logic [1:0] TRI_CYL_A = 2'd2;
    localparam logic [1:0] TRI_CYL_B = 2'd3;

    // Wide working coordinate before saturation.
    localparam int WIDE_W = 36;

    typedef logic [RING_W-1:0]        ring_t;
    typedef logic [SEG_W-1:0]         seg_t;
    typedef logic signed [17:0]       trig_t;
    typedef logic signed [WIDE_W-1:0] wide_t;

    typedef struct packed {
        logic is_box;
        logic hit;
        logic last;
    } tri_flags_t;

    // Q16.16 sine/cosine of ring polar angles (ring / (2*RINGS) of a turn).
    function automatic trig_t ring_sin(input ring_t r);
        trig_t v;
        case (r)
            3'd0:    v = 18'sd0;
            3'd1:    v = 18'sd32768;
            3'd2:    v = 18'sd56756;
            3'd3:    v = 18'sd65536;
            3'd4:    v = 18'sd56756;
            3'd5:    v = 18'sd32768;
            3'd6:    v = 18'sd0;
            default: v = 18'sd0;
        endcase
        return v;
    endfunction

    function automatic trig_t ring_cos(input ring_t r);
        trig_t v;
        case (r)
            3'd0:    v = 18'sd65536;
            3'd1:    v = 18'sd56756;
            3'd2:    v = 18'sd32768;
            3'd3:    v = 18'sd0;
            3'd4:    v = -18'sd32768;
            3'd5:    v = -18'sd56756;
            3'd6:    v = -18'sd65536;
            default: v = 18'sd0;
        endcase
        return v;
    endfunction

    // Q16.16 sine/cosine of segment azimuths (seg / SEGMENTS of a turn).
    function automatic trig_t seg_sin(input seg_t s);
        trig_t v;
        case (s)
            3'd0:    v = 18'sd0;
            3'd1:    v = 18'sd46341;
            3'd2:    v = 18'sd65536;
            3'd3:    v = 18'sd46341;
            3'd4:    v = 18'sd0;
            3'd5:    v = -18'sd46341;
            3'd6:    v = -18'sd65536;
            3'd7:    v = -18'sd46341;
            default: v = 18'sd0;
        endcase
        return v;
    endfunction

    function automatic trig_t seg_cos(input seg_t s);
        trig_t v;
        case (s)
            3'd0:    v = 18'sd65536;
            3'd1:    v = 18'sd46341;
            3'd2:    v = 18'sd0;
            3'd3:    v = -18'sd46341;
            3'd4:    v = -18'sd65536;
            3'd5:    v = -18'sd46341;
            3'd6:    v = 18'sd0;
            3'd7:    v = 18'sd46341;
            default: v = 18'sd0;
        endcase
        return v;
    endfunction

    // Box corner sign bits (bit0 +x, bit1 +y, bit2 +z) by corner number.
    function automatic logic [2:0] box_sign(input logic [2:0] c);
        logic [2:0] v;
        case (c)
            3'd0:    v = 3'd0;
            3'd1:    v = 3'd1;
            3'd2:    v = 3'd5;
            3'd3:    v = 3'd4;
            3'd4:    v = 3'd2;
            3'd5:    v = 3'd3;
            3'd6:    v = 3'd7;
            3'd7:    v = 3'd6;
            default: v = 3'd0;
        endcase
        return v;
    endfunction

    // Corner number of face f, position p (0..3).
    function automatic logic [2:0] box_face(input logic [2:0] f, input logic [1:0] p);
        logic [11:0] row;
        case (f)
            3'd0:    row = {3'd5, 3'd6, 3'd7, 3'd4};
            3'd1:    row = {3'd3, 3'd2, 3'd1, 3'd0};
            3'd2:    row = {3'd1, 3'd5, 3'd4, 3'd0};
            3'd3:    row = {3'd7, 3'd6, 3'd2, 3'd3};
            3'd4:    row = {3'd4, 3'd7, 3'd3, 3'd0};
            3'd5:    row = {3'd2, 3'd6, 3'd5, 3'd1};
            default: row = 12'd0;
        endcase
        return row[p*3 +: 3];
    endfunction

endpackage
`default_nettype wire

// File: sv/collider_triangle_generator.sv
// Top level of the collider triangle generator: index decode, corner lanes and output stage.
`timescale 1ns / 1ps
`default_nettype none
// Each input word names a collider (box, sphere or capsule), its sizes in Q16.16 and the
// index of one triangle of that collider's emitted list; the output word carries the three
// corners of that triangle plus an in-range flag (tuser) and a final-triangle flag (tlast).
// A box gives 12 triangles, a sphere 80 on a 6-ring by 8-segment grid, a capsule 80 plus
// 16 cylinder triangles when its half height is positive. An out-of-range index returns
// all-zero corners with the flag low. The block takes one word per cycle while the output
// is not stalled; the word passes the decode register, three multiply/round stages in each
// corner lane, then the saturating output register. The whole pipeline advances together,
// so a stall on the output holds every stage and the input is not ready while the output
// word waits; the input is also not ready in reset.
module collider_triangle_generator #(
    parameter int COORD_WIDTH = 32
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    // half_x[31:0], half_y[63:32], half_z[95:64], radius[126:96],
    // half_height[158:127], tri_index[165:159], zero fill
    input  wire logic [167:0]  s_axis_tdata,
    // shape_kind[1:0]
    input  wire logic [1:0]    s_axis_tuser,
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // ax, ay, az, bx, by, bz, cx, cy, cz, 32 bits each from the lowest bit up
    output logic [287:0]       m_axis_tdata,
    // valid_res[0]
    output logic               m_axis_tuser,
    // last
    output logic               m_axis_tlast
);

    localparam int SAT_W = (COORD_WIDTH > 32) ? 32 : COORD_WIDTH;
    localparam ctg_pkg::wide_t SAT_HI = (36'sd1 <<< (SAT_W - 1)) - 36'sd1;
    localparam ctg_pkg::wide_t SAT_LO = -SAT_HI - 36'sd1;

    // Unpack the input word.
    logic [1:0]         kind;
    logic signed [31:0] half_x, half_y, half_z, half_height;
    logic [30:0]        radius;
    logic [6:0]         tri_index;

    assign kind        = s_axis_tuser;
    assign half_x      = s_axis_tdata[31:0];
    assign half_y      = s_axis_tdata[63:32];
    assign half_z      = s_axis_tdata[95:64];
    assign radius      = s_axis_tdata[126:96];
    assign half_height = s_axis_tdata[158:127];
    assign tri_index   = s_axis_tdata[165:159];

    // Global advance: every stage moves when the output register is free or being taken.
    logic en;
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en && rst_n;

    // ---------------- decode (feeds stage 0 registers) ----------------
    logic [7:0]           count;
    ctg_pkg::tri_flags_t  flags_next;
    logic [7:0]           idx, t1, t2, t3;
    ctg_pkg::ring_t       ring;
    logic [7:0]           seg_w;
    ctg_pkg::seg_t        seg, seg_nx;
    logic [1:0]           tri_kind;
    ctg_pkg::wide_t       hh;
    ctg_pkg::ring_t       c_ring [3];
    ctg_pkg::seg_t        c_seg  [3];
    logic                 c_cyl  [3];
    ctg_pkg::wide_t       c_lift [3];
    logic [2:0]           face;
    logic [2:0]           bsel   [3];
    logic [2:0]           bsgn;
    logic [8:0][35:0]     box_next;
    ctg_pkg::wide_t       hx, hy, hz;

    always_comb
    begin
        idx = {1'b0, tri_index};
        hh  = (kind == ctg_pkg::KIND_CAPSULE) ? ctg_pkg::wide_t'(half_height) : '0;

        case (kind)
            ctg_pkg::KIND_BOX:     count = 8'(ctg_pkg::BOX_CNT);
            ctg_pkg::KIND_SPHERE:  count = 8'(ctg_pkg::HULL_CNT);
            ctg_pkg::KIND_CAPSULE: count = (hh > 0) ? 8'(ctg_pkg::HULL_CNT + ctg_pkg::CYL_CNT)
                                                    : 8'(ctg_pkg::HULL_CNT);
            default:               count = 8'd0;
        endcase
        flags_next.is_box = (kind == ctg_pkg::KIND_BOX);
        flags_next.hit    = (idx < count);
        flags_next.last   = (idx < count) && (idx == count - 8'd1);

        // Walk the hull list: cap ring, middle bands, bottom ring, cylinder.
        // Each middle band holds 2*SEGMENTS triangles, a power of two.
        t1 = idx - 8'(ctg_pkg::SEGMENTS);
        t2 = t1 - 8'(ctg_pkg::HULL_MID);
        t3 = t2 - 8'(ctg_pkg::SEGMENTS);
        if (idx < 8'(ctg_pkg::SEGMENTS))
        begin
            ring     = '0;
            seg_w    = idx;
            tri_kind = ctg_pkg::TRI_DBC;
        end
        else if (t1 < 8'(ctg_pkg::HULL_MID))
        begin
            ring     = ctg_pkg::ring_t'(8'd1 + (t1 >> (ctg_pkg::SEG_W + 1)));
            seg_w    = (t1 & 8'(2 * ctg_pkg::SEGMENTS - 1)) >> 1;
            tri_kind = t1[0] ? ctg_pkg::TRI_DBC : ctg_pkg::TRI_ABD;
        end
        else if (t2 < 8'(ctg_pkg::SEGMENTS))
        begin
            ring     = ctg_pkg::ring_t'(ctg_pkg::RINGS - 1);
            seg_w    = t2;
            tri_kind = ctg_pkg::TRI_ABD;
        end
        else
        begin
            ring     = ctg_pkg::ring_t'(ctg_pkg::RING_MID);
            seg_w    = t3 >> 1;
            tri_kind = t3[0] ? ctg_pkg::TRI_CYL_B : ctg_pkg::TRI_CYL_A;
        end
        seg    = seg_w[ctg_pkg::SEG_W-1:0];
        seg_nx = (seg == ctg_pkg::seg_t'(ctg_pkg::SEGMENTS - 1)) ? '0 : seg + 1'b1;

        // Pick the grid point of each corner.
        case (tri_kind)
            ctg_pkg::TRI_ABD:
            begin
                c_ring[0] = ring;         c_seg[0] = seg;    c_cyl[0] = 1'b0;
                c_ring[1] = ring + 1'b1;  c_seg[1] = seg;    c_cyl[1] = 1'b0;
                c_ring[2] = ring;         c_seg[2] = seg_nx; c_cyl[2] = 1'b0;
            end
            ctg_pkg::TRI_DBC:
            begin
                c_ring[0] = ring;         c_seg[0] = seg_nx; c_cyl[0] = 1'b0;
                c_ring[1] = ring + 1'b1;  c_seg[1] = seg;    c_cyl[1] = 1'b0;
                c_ring[2] = ring + 1'b1;  c_seg[2] = seg_nx; c_cyl[2] = 1'b0;
            end
            ctg_pkg::TRI_CYL_A:
            begin
                c_ring[0] = ring;         c_seg[0] = seg;    c_cyl[0] = 1'b0;
                c_ring[1] = ring;         c_seg[1] = seg;    c_cyl[1] = 1'b1;
                c_ring[2] = ring;         c_seg[2] = seg_nx; c_cyl[2] = 1'b0;
            end
            default:
            begin
                c_ring[0] = ring;         c_seg[0] = seg_nx; c_cyl[0] = 1'b0;
                c_ring[1] = ring;         c_seg[1] = seg;    c_cyl[1] = 1'b1;
                c_ring[2] = ring;         c_seg[2] = seg_nx; c_cyl[2] = 1'b1;
            end
        endcase

        // Upper half rides up by the half height, lower half down; cylinder
        // corners drop a further full height.
        for (int k = 0; k < 3; k++)
        begin
            c_lift[k] = (c_ring[k] <= ctg_pkg::ring_t'(ctg_pkg::RING_MID)) ? hh : -hh;
            if (c_cyl[k])
                c_lift[k] = c_lift[k] - (hh <<< 1);
        end

        // Box corners straight from the face table.
        face    = tri_index[3:1];
        bsel[0] = ctg_pkg::box_face(face, 2'd0);
        bsel[1] = ctg_pkg::box_face(face, tri_index[0] ? 2'd2 : 2'd1);
        bsel[2] = ctg_pkg::box_face(face, tri_index[0] ? 2'd3 : 2'd2);
        hx = ctg_pkg::wide_t'(half_x);
        hy = ctg_pkg::wide_t'(half_y);
        hz = ctg_pkg::wide_t'(half_z);
        for (int k = 0; k < 3; k++)
        begin
            bsgn = ctg_pkg::box_sign(bsel[k]);
            box_next[k*3+0] = bsgn[0] ? hx : -hx;
            box_next[k*3+1] = bsgn[1] ? hy : -hy;
            box_next[k*3+2] = bsgn[2] ? hz : -hz;
        end
    end

    // ---------------- stage 0 registers ----------------
    logic [30:0]          rad0_reg;
    ctg_pkg::trig_t       sp0_reg [3], cp0_reg [3], sa0_reg [3], ca0_reg [3];
    ctg_pkg::wide_t       lift0_reg [3];
    logic [8:0][35:0]     box0_reg, box1_reg, box2_reg, box3_reg;
    ctg_pkg::tri_flags_t  flags0_reg, flags1_reg, flags2_reg, flags3_reg;
    logic [3:0]           vld_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad0_reg <= radius;
            for (int k = 0; k < 3; k++)
            begin
                sp0_reg[k]   <= ctg_pkg::ring_sin(c_ring[k]);
                cp0_reg[k]   <= ctg_pkg::ring_cos(c_ring[k]);
                sa0_reg[k]   <= ctg_pkg::seg_sin(c_seg[k]);
                ca0_reg[k]   <= ctg_pkg::seg_cos(c_seg[k]);
                lift0_reg[k] <= c_lift[k];
            end
            // Hold box corners and flags alongside the lane stages.
            box0_reg   <= box_next;
            box1_reg   <= box0_reg;
            box2_reg   <= box1_reg;
            box3_reg   <= box2_reg;
            flags0_reg <= flags_next;
            flags1_reg <= flags0_reg;
            flags2_reg <= flags1_reg;
            flags3_reg <= flags2_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            m_axis_tvalid <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= {vld_reg[2:0], s_axis_tvalid};
            m_axis_tvalid <= vld_reg[3];
        end
    end

    // ---------------- corner lanes (stages 1..3) ----------------
    ctg_pkg::wide_t lane_x [3], lane_y [3], lane_z [3];

    for (genvar g = 0; g < 3; g++)
    begin : g_lane
        ctg_point u_point (
            .clk    (clk),
            .en     (en),
            .radius (rad0_reg),
            .sin_p  (sp0_reg[g]),
            .cos_p  (cp0_reg[g]),
            .sin_a  (sa0_reg[g]),
            .cos_a  (ca0_reg[g]),
            .lift   (lift0_reg[g]),
            .x      (lane_x[g]),
            .y      (lane_y[g]),
            .z      (lane_z[g])
        );
    end

    // ---------------- output stage: select, zero on miss, saturate ----------------
    function automatic logic [31:0] sat(input ctg_pkg::wide_t v);
        ctg_pkg::wide_t s;
        s = (v > SAT_HI) ? SAT_HI : ((v < SAT_LO) ? SAT_LO : v);
        return s[31:0];
    endfunction

    logic [287:0] tdata_next;
    ctg_pkg::wide_t coord;

    always_comb
    begin
        tdata_next = '0;
        for (int k = 0; k < 3; k++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                if (!flags3_reg.hit)
                    coord = '0;
                else if (flags3_reg.is_box)
                    coord = $signed(box3_reg[k*3+j]);
                else if (j == 0)
                    coord = lane_x[k];
                else if (j == 1)
                    coord = lane_y[k];
                else
                    coord = lane_z[k];
                tdata_next[(k*3+j)*32 +: 32] = sat(coord);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_axis_tdata <= tdata_next;
            m_axis_tuser <= flags3_reg.hit;
            m_axis_tlast <= flags3_reg.last;
        end
    end

endmodule
`default_nettype wire

// File: sv/ctg_point.sv
// One hull corner lane: trig products, radius scaling and rounding over three stages.
`timescale 1ns / 1ps
`default_nettype none
module ctg_point (
    input  wire logic                   clk,
    input  wire logic                   en,
    input  wire logic [30:0]            radius,
    input  wire ctg_pkg::trig_t         sin_p,
    input  wire ctg_pkg::trig_t         cos_p,
    input  wire ctg_pkg::trig_t         sin_a,
    input  wire ctg_pkg::trig_t         cos_a,
    input  wire ctg_pkg::wide_t         lift,
    output ctg_pkg::wide_t              x,
    output ctg_pkg::wide_t              y,
    output ctg_pkg::wide_t              z
);

    // round half away from zero, drop 32 fraction bits
    function automatic ctg_pkg::wide_t rnd32(input logic signed [67:0] v);
        logic [67:0] mag;
        logic [67:0] r;
        mag = v[67] ? 68'(-v) : 68'(v);
        r   = (mag + (68'd1 << 31)) >> 32;
        return v[67] ? -$signed(r[ctg_pkg::WIDE_W-1:0]) : $signed(r[ctg_pkg::WIDE_W-1:0]);
    endfunction

    // round half away from zero, drop 16 fraction bits
    function automatic ctg_pkg::wide_t rnd16(input logic signed [49:0] v);
        logic [49:0] mag;
        logic [49:0] r;
        mag = v[49] ? 50'(-v) : 50'(v);
        r   = (mag + (50'd1 << 15)) >> 16;
        return v[49] ? -$signed(r[ctg_pkg::WIDE_W-1:0]) : $signed(r[ctg_pkg::WIDE_W-1:0]);
    endfunction

    logic [30:0]         rad1_reg;
    logic signed [35:0]  sc1_reg, ss1_reg;
    logic signed [49:0]  ycp1_reg;
    ctg_pkg::wide_t      lift1_reg;
    logic signed [67:0]  mx2_reg, mz2_reg;
    ctg_pkg::wide_t      y2_reg;
    ctg_pkg::wide_t      x3_reg, y3_reg, z3_reg;

    logic signed [35:0]  sc1_next, ss1_next;
    logic signed [49:0]  ycp1_next;
    logic signed [67:0]  mx2_next, mz2_next;
    ctg_pkg::wide_t      y2_next;

    always_comb
    begin
        sc1_next  = sin_p * cos_a;
        ss1_next  = sin_p * sin_a;
        ycp1_next = $signed({1'b0, radius}) * cos_p;
        mx2_next  = $signed({1'b0, rad1_reg}) * sc1_reg;
        mz2_next  = $signed({1'b0, rad1_reg}) * ss1_reg;
        y2_next   = rnd16(ycp1_reg) + lift1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad1_reg  <= radius;
            sc1_reg   <= sc1_next;
            ss1_reg   <= ss1_next;
            ycp1_reg  <= ycp1_next;
            lift1_reg <= lift;
            mx2_reg   <= mx2_next;
            mz2_reg   <= mz2_next;
            y2_reg    <= y2_next;
            x3_reg    <= rnd32(mx2_reg);
            y3_reg    <= y2_reg;
            z3_reg    <= -rnd32(mz2_reg);
        end
    end

    assign x = x3_reg;
    assign y = y3_reg;
    assign z = z3_reg;

endmodule
`default_nettype wire

// File: verif/collider_triangle_generator_test.sv
// Testbench for the collider triangle generator: random and directed requests checked against a predictor.
`timescale 1ns / 1ps
`default_nettype none

typedef struct {
    logic [31:0] crd [9];
    logic        hit;
    logic        fin;
} tri_word_t;

class tri_scoreboard;
    tri_word_t pending[$];
    int        errors;

    function void note_request(tri_word_t w);
        pending.push_back(w);
    endfunction

    // Compare one output word against the oldest prediction; return mismatch count.
    function int check_word(logic [287:0] d, logic u, logic l, output string msg);
        tri_word_t w;
        int        bad;
        bad = 0;
        msg = "";
        if (pending.size() == 0)
        begin
            msg = "output word with no request waiting";
            return 1;
        end
        w = pending.pop_front();
        for (int i = 0; i < 9; i++)
            if (d[i*32 +: 32] !== w.crd[i])
            begin
                bad++;
                msg = $sformatf("coord %0d got %h want %h", i, d[i*32 +: 32], w.crd[i]);
            end
        if (u !== w.hit)
        begin
            bad++;
            msg = $sformatf("in-range flag got %b want %b", u, w.hit);
        end
        if (l !== w.fin)
        begin
            bad++;
            msg = $sformatf("final flag got %b want %b", l, w.fin);
        end
        return bad;
    endfunction
endclass

module collider_triangle_generator_test;

    localparam longint PI_HALF_Q30 = 64'd1686629713;
    localparam int     CYCLE_LIMIT = 400000;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [167:0] s_axis_tdata = '0;
    logic [1:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [287:0] m_axis_tdata;
    logic         m_axis_tuser;
    logic         m_axis_tlast;

    tri_scoreboard sb;
    int            cycles = 0;
    int            fails = 0;
    bit            sending_done = 0;
    bit            hold_off = 0;

    always #2 clk = ~clk;

    collider_triangle_generator dut (.*);

    always @(posedge clk) cycles <= cycles + 1;

    task automatic report(string msg);
        fails++;
        $display("mismatch at cycle %0d: %s", cycles, msg);
    endtask

    // Taylor-series sine/cosine of num/den of a full turn, Q16.16.
    function automatic void turn_trig(int num, int den, output longint s, output longint c);
        longint unsigned q, r, x, x2, ts, tc;
        longint          ss, cs, qs, qc;
        q = (4 * num) / den;
        r = 4 * num - q * den;
        x = (PI_HALF_Q30 * r) / den;
        x2 = (x * x) >> 30;
        ts = x;
        tc = 64'd1 << 30;
        ss = x;
        cs = 64'sd1 << 30;
        for (int k = 1; k <= 7; k++)
        begin
            ts = ((ts * x2) >> 30) / ((2 * k) * (2 * k + 1));
            tc = ((tc * x2) >> 30) / ((2 * k - 1) * (2 * k));
            if (k & 1)
            begin
                ss -= ts;
                cs -= tc;
            end
            else
            begin
                ss += ts;
                cs += tc;
            end
        end
        qs = (ss < 0) ? 0 : ((ss + 8192) >>> 14);
        qc = (cs < 0) ? 0 : ((cs + 8192) >>> 14);
        case (q & 3)
            0: begin s = qs;  c = qc;  end
            1: begin s = qc;  c = -qs; end
            2: begin s = -qs; c = -qc; end
            default: begin s = -qc; c = qs; end
        endcase
    endfunction

    // Round half away from zero after a right shift; operands stay within 64 bits here.
    function automatic longint round_shift(longint v, int sh);
        longint half;
        half = 64'sd1 <<< (sh - 1);
        if (v >= 0)
            return (v + half) >>> sh;
        return -((-v + half) >>> sh);
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // rnd(rad * t / 2^32) with a 96-bit intermediate.
    function automatic longint wide_round(longint rad, longint t);
        logic signed [95:0] m;
        logic signed [95:0] a;
        m = 96'(rad) * 96'(t);
        if (m >= 0)
            a = (m + (96'sd1 <<< 31)) >>> 32;
        else
            a = -((-m + (96'sd1 <<< 31)) >>> 32);
        return longint'(a);
    endfunction

    function automatic void grid_point(int ring, int seg, longint rad, longint hh,
                                       output longint p [3]);
        longint sp, cp, sa, ca;
        turn_trig(ring, 2 * ctg_pkg::RINGS, sp, cp);
        turn_trig(seg % ctg_pkg::SEGMENTS, ctg_pkg::SEGMENTS, sa, ca);
        // radius times a product of two trig values can pass 64 bits; go wide.
        p[0] = wide_round(rad, sp * ca);
        p[1] = round_shift(rad * cp, 16) + ((ring <= ctg_pkg::RING_MID) ? hh : -hh);
        p[2] = -wide_round(rad, sp * sa);
    endfunction

    function automatic logic [2:0] corner_sign(logic [2:0] n);
        logic [2:0] m [8] = '{3'd0, 3'd1, 3'd5, 3'd4, 3'd2, 3'd3, 3'd7, 3'd6};
        return m[n];
    endfunction

    function automatic logic [2:0] box_face_ref(int f, int p);
        logic [2:0] rows [6][4] = '{'{4, 7, 6, 5}, '{0, 1, 2, 3}, '{0, 4, 5, 1},
                                    '{3, 2, 6, 7}, '{0, 3, 7, 4}, '{1, 5, 6, 2}};
        return rows[f][p];
    endfunction

    // Work out the triangle a request selects.
    function automatic tri_word_t predict_triangle(logic [1:0] kind, logic [167:0] d);
        tri_word_t  w;
        longint     h [3], rad, hh, a [3], b [3], c [3], e [3], v [3][3];
        int         cnt, idx, t, ring, seg, shape;
        logic [2:0] sel [3];
        logic [2:0] sgn;
        for (int j = 0; j < 3; j++)
            h[j] = longint'($signed(d[j*32 +: 32]));
        rad = longint'(d[126:96]);
        hh = (kind == ctg_pkg::KIND_CAPSULE) ? longint'($signed(d[158:127])) : 0;
        idx = d[165:159];
        if (kind == ctg_pkg::KIND_BOX)
            cnt = ctg_pkg::BOX_CNT;
        else if (kind == ctg_pkg::KIND_SPHERE || kind == ctg_pkg::KIND_CAPSULE)
            cnt = ctg_pkg::HULL_CNT +
                  ((kind == ctg_pkg::KIND_CAPSULE && hh > 0) ? ctg_pkg::CYL_CNT : 0);
        else
            cnt = 0;
        foreach (w.crd[i])
            w.crd[i] = '0;
        w.hit = 1'b0;
        w.fin = 1'b0;
        if (idx >= cnt)
            return w;
        if (kind == ctg_pkg::KIND_BOX)
        begin
            sel[0] = box_face_ref(idx >> 1, 0);
            sel[1] = box_face_ref(idx >> 1, (idx & 1) ? 2 : 1);
            sel[2] = box_face_ref(idx >> 1, (idx & 1) ? 3 : 2);
            for (int i = 0; i < 3; i++)
            begin
                sgn = corner_sign(sel[i]);
                for (int j = 0; j < 3; j++)
                    v[i][j] = sgn[j] ? h[j] : -h[j];
            end
        end
        else
        begin
            t = idx;
            if (t < ctg_pkg::SEGMENTS)
            begin
                ring = 0; seg = t; shape = ctg_pkg::TRI_DBC;
            end
            else if (t - ctg_pkg::SEGMENTS < ctg_pkg::HULL_MID)
            begin
                t -= ctg_pkg::SEGMENTS;
                ring = 1 + t / (2 * ctg_pkg::SEGMENTS);
                seg = (t % (2 * ctg_pkg::SEGMENTS)) >> 1;
                shape = t & 1;
            end
            else if (t - ctg_pkg::SEGMENTS - ctg_pkg::HULL_MID < ctg_pkg::SEGMENTS)
            begin
                ring = ctg_pkg::RINGS - 1;
                seg = t - ctg_pkg::SEGMENTS - ctg_pkg::HULL_MID;
                shape = ctg_pkg::TRI_ABD;
            end
            else
            begin
                t -= 2 * ctg_pkg::SEGMENTS + ctg_pkg::HULL_MID;
                ring = ctg_pkg::RING_MID; seg = t >> 1;
                shape = ctg_pkg::TRI_CYL_A + (t & 1);
            end
            if (shape == ctg_pkg::TRI_ABD || shape == ctg_pkg::TRI_DBC)
            begin
                grid_point(ring, seg, rad, hh, a);
                grid_point(ring + 1, seg, rad, hh, b);
                grid_point(ring + 1, seg + 1, rad, hh, c);
                grid_point(ring, seg + 1, rad, hh, e);
                for (int j = 0; j < 3; j++)
                begin
                    v[0][j] = (shape == ctg_pkg::TRI_DBC) ? e[j] : a[j];
                    v[1][j] = b[j];
                    v[2][j] = (shape == ctg_pkg::TRI_DBC) ? c[j] : e[j];
                end
            end
            else
            begin
                grid_point(ring, seg, rad, hh, a);
                grid_point(ring, seg + 1, rad, hh, b);
                c = a;
                e = b;
                c[1] -= 2 * hh;
                e[1] -= 2 * hh;
                for (int j = 0; j < 3; j++)
                begin
                    v[0][j] = (shape == ctg_pkg::TRI_CYL_A) ? a[j] : b[j];
                    v[1][j] = c[j];
                    v[2][j] = (shape == ctg_pkg::TRI_CYL_A) ? b[j] : e[j];
                end
            end
        end
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                w.crd[i*3+j] = 32'(clamp32(v[i][j]));
        w.hit = 1'b1;
        w.fin = (idx == cnt - 1);
        return w;
    endfunction

    function automatic logic [31:0] rand_extent();
        case ($urandom_range(0, 5))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 32'h0010_0000);
            3: return -$urandom_range(0, 32'h0010_0000);
            default: return $urandom;
        endcase
    endfunction

    // Offer one request and hold it until the block takes it.
    task automatic send_request(logic [1:0] kind, logic [31:0] hx, logic [31:0] hy,
                                logic [31:0] hz, logic [30:0] rad, logic [31:0] hh,
                                logic [6:0] idx, bit allow_gap);
        logic [167:0] d;
        int           gap;
        d = {2'b00, idx, hh, rad, hz, hy, hx};
        gap = 0;
        if (allow_gap)
            gap = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 40) :
                  ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= d;
        s_axis_tuser <= kind;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_request(predict_triangle(kind, d));
    endtask

    // Output side: random stalls plus one long hold-off.
    always @(posedge clk)
    begin
        string msg;
        if (rst_n && m_axis_tvalid && m_axis_tready)
            if (sb.check_word(m_axis_tdata, m_axis_tuser, m_axis_tlast, msg) != 0)
                report(msg);
        if (hold_off)
            m_axis_tready <= 1'b0;
        else if ($urandom_range(0, 29) == 0)
            m_axis_tready <= 1'b0;
        else if ($urandom_range(0, 3) != 0)
            m_axis_tready <= 1'b1;
    end

    initial
    begin
        sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
    end

    // Long receiver hold-off while requests keep coming.
    initial
    begin
        repeat (300) @(posedge clk);
        hold_off = 1;
        repeat (200) @(posedge clk);
        hold_off = 0;
    end

    initial
    begin
        logic [1:0] kind;
        logic [6:0] idx;
        @(posedge rst_n);
        @(posedge clk);
        // Directed: box extremes, sphere/capsule bounds, kind 3, out-of-range indexes.
        send_request(ctg_pkg::KIND_BOX, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000,
                     0, 0, 0, 0);
        send_request(ctg_pkg::KIND_BOX, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_0000,
                     0, 0, 11, 0);
        send_request(ctg_pkg::KIND_BOX, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                     0, 0, 12, 0);
        send_request(ctg_pkg::KIND_BOX, 32'hffff_ffff, 32'h0000_0001, 32'h1234_5678,
                     0, 0, 127, 0);
        send_request(ctg_pkg::KIND_SPHERE, 0, 0, 0, 31'h7fff_ffff, 32'h7fff_ffff, 0, 0);
        send_request(ctg_pkg::KIND_SPHERE, 0, 0, 0, 31'h0001_0000, 0, 79, 0);
        send_request(ctg_pkg::KIND_SPHERE, 0, 0, 0, 31'h0001_0000, 0, 80, 0);
        send_request(ctg_pkg::KIND_SPHERE, 0, 0, 0, 31'h7fff_ffff, 0, 40, 0);
        send_request(ctg_pkg::KIND_CAPSULE, 0, 0, 0, 31'h0001_0000, 32'h0001_0000, 95, 0);
        send_request(ctg_pkg::KIND_CAPSULE, 0, 0, 0, 31'h0001_0000, 32'h0001_0000, 80, 0);
        send_request(ctg_pkg::KIND_CAPSULE, 0, 0, 0, 31'h0001_0000, 32'h0001_0000, 96, 0);
        send_request(ctg_pkg::KIND_CAPSULE, 0, 0, 0, 31'h0001_0000, 32'hffff_0000, 79, 0);
        send_request(ctg_pkg::KIND_CAPSULE, 0, 0, 0, 31'h0001_0000, 32'hffff_0000, 80, 0);
        send_request(ctg_pkg::KIND_CAPSULE, 0, 0, 0, 31'h7fff_ffff, 32'h7fff_ffff, 88, 0);
        send_request(ctg_pkg::KIND_CAPSULE, 0, 0, 0, 31'h7fff_ffff, 32'h8000_0000, 10, 0);
        send_request(ctg_pkg::KIND_CAPSULE, 0, 0, 0, 31'h7fff_ffff, 32'h0000_0000, 95, 0);
        send_request(2'd3, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 31'h7fff_ffff,
                     32'hffff_ffff, 0, 0);
        send_request(2'd3, 0, 0, 0, 0, 0, 127, 0);
        // Random: mostly in-range indexes, some past the end.
        for (int n = 0; n < 1500; n++)
        begin
            kind = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
            if ($urandom_range(0, 9) == 0)
                idx = 7'($urandom);
            else
                idx = 7'($urandom_range(0, kind == ctg_pkg::KIND_BOX ? 11 : 95));
            send_request(kind, rand_extent(), rand_extent(), rand_extent(),
                         31'(rand_extent()), rand_extent(), idx, 1);
        end
        s_axis_tvalid <= 1'b0;
        sending_done = 1;
    end

    // End of run: drain, then settle, or give up at the cycle limit.
    initial
    begin
        @(posedge clk);
        while (!(sending_done && sb.pending.size() == 0) && cycles < CYCLE_LIMIT)
            @(posedge clk);
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
        begin
            repeat (20) @(posedge clk);
            if (fails == 0 && sb.pending.size() == 0)
                $display("PASS");
            else
                $display("FAIL");
            $finish;
        end
    end
endmodule
`default_nettype wire
